/* src/sample_scale_delta_history_defines.svh */
// Assertion macros for the sample scaler with history ring.
// Used by the top level only; no other dependencies.
`ifndef SAMPLE_SCALE_DELTA_HISTORY_DEFINES_SVH
`define SAMPLE_SCALE_DELTA_HISTORY_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSDH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ssdh assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSDH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ssdh assertion failed");

// Next-cycle implication that is also checked across reset.
`define SSDH_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ssdh assertion failed");

`endif

/* src/ssdh_pkg.sv */
// Shared types and constants for the sample scaler with history ring.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ssdh_pkg;

    localparam int RingDepthDefault = 16;
    localparam int MaxOut           = 16;
    localparam int CountW           = 5;
    localparam int ValW             = 48;

    localparam logic [31:0] FLAG_VALID  = 32'h0000_0001;
    localparam logic [31:0] FLAG_AFFINE = 32'h0000_0002;
    localparam logic [31:0] FLAG_DELTA  = 32'h0000_0004;

    localparam logic signed [31:0]     GAIN_ONE = 32'sh0001_0000;
    localparam logic signed [ValW-1:0] VAL_MAX  = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [ValW-1:0] VAL_MIN  = 48'sh8000_0000_0000;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_LATEST = 2'd1,
        MODE_SNAP   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_INVERT   = 2'd0,
        REG_DELTA_EN = 2'd1,
        REG_GAIN     = 2'd2,
        REG_OFFSET   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] raw_sample;
        logic [31:0]        time_ticks;
        logic [31:0]        in_flags;
        logic [CountW-1:0]  want_count;
    } ssdh_in_t;

    typedef struct packed {
        logic                   found;
        logic [31:0]            seq_index;
        logic [31:0]            stamp;
        logic [31:0]            out_flags;
        logic signed [ValW-1:0] mapped_value;
        logic signed [ValW-1:0] delta_value;
        logic                   last;
    } ssdh_out_t;

    typedef struct packed {
        logic [31:0]            seq_index;
        logic [31:0]            stamp;
        logic [31:0]            flags;
        logic signed [ValW-1:0] value;
        logic signed [ValW-1:0] delta;
    } ssdh_entry_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch input word, query count and start slot
        logic mul;         // raw * gain
        logic add;         // + offset, saturate
        logic push_wr;     // write ring, load output, update history state
        logic load_empty;  // load the not-found word
        logic rd_issue;    // ring read
        logic rd_load;     // load output from ring read data, step pointer
    } ssdh_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic qry_empty;
        logic rd_last;
    } ssdh_status_t;

endpackage

`default_nettype wire

/* src/ssdh_datapath.sv */
// Datapath: config registers, scale/offset/delta arithmetic, history ring,
// read pointer and output register. Depends on ssdh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssdh_datapath
    import ssdh_pkg::*;
#(
    parameter int RING_DEPTH = RingDepthDefault
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [ValW-1:0]   cfg_wdata,
    input  wire ssdh_in_t          s_data,
    input  wire ssdh_cmd_t         cmd,
    output ssdh_status_t           status,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ssdh_out_t              m_data
);

    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int NW = (FW > CountW) ? FW : CountW;
    localparam logic [PW:0]   DepthX   = (PW + 1)'(RING_DEPTH);
    localparam logic [PW-1:0] PtrLast  = PW'(RING_DEPTH - 1);
    localparam logic [FW-1:0] FillFull = FW'(RING_DEPTH);

    // configuration
    logic                   invert_reg;
    logic                   delta_en_reg;
    logic signed [31:0]     gain_reg;
    logic signed [ValW-1:0] offset_reg;

    // item latch and arithmetic stages
    logic signed [31:0]     raw_reg;
    logic [31:0]            stamp_in_reg;
    logic [31:0]            flags_in_reg;
    logic signed [64:0]     prod_reg;
    logic signed [ValW-1:0] val_reg;

    // history state
    logic [PW-1:0]          wp_reg;
    logic [FW-1:0]          fill_reg;
    logic [31:0]            seq_reg;
    logic                   prev_valid_reg;
    logic signed [ValW-1:0] prev_value_reg;
    ssdh_entry_t            mem [RING_DEPTH];
    ssdh_entry_t            rd_data_reg;

    // query read-out
    logic [PW-1:0]          rd_ptr_reg;
    logic [CountW-1:0]      rd_left_reg;

    logic                   out_valid_reg;
    ssdh_out_t              out_reg;

    // combinational
    logic [CountW-1:0]      want_clamp;
    logic [NW-1:0]          fill_ext;
    logic [NW-1:0]          want_ext;
    logic [NW-1:0]          n_min;
    logic [CountW-1:0]      qry_n;
    logic                   qry_empty;
    logic [PW:0]            start_sum;
    logic [PW-1:0]          rd_start;
    logic signed [32:0]     raw_eff;
    logic signed [65:0]     sum;
    logic signed [ValW-1:0] val_next;
    logic signed [ValW:0]   diff;
    logic signed [ValW-1:0] delta_sat;
    logic                   do_delta;
    logic                   affine;
    ssdh_entry_t            new_entry;
    logic                   out_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_reg   <= 1'b0;
            delta_en_reg <= 1'b1;
            gain_reg     <= GAIN_ONE;
            offset_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_INVERT:   invert_reg   <= cfg_wdata[0];
                REG_DELTA_EN: delta_en_reg <= cfg_wdata[0];
                REG_GAIN:     gain_reg     <= cfg_wdata[31:0];
                REG_OFFSET:   offset_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // query size: latest is one word, snapshot is min(clamped want, fill)
    always_comb begin
        want_clamp = (s_data.want_count > CountW'(MaxOut)) ? CountW'(MaxOut)
                                                            : s_data.want_count;
        fill_ext   = NW'(fill_reg);
        want_ext   = NW'(want_clamp);
        n_min      = (fill_ext < want_ext) ? fill_ext : want_ext;
        if (s_data.mode == MODE_LATEST) begin
            qry_n     = CountW'(1);
            qry_empty = (fill_reg == '0);
        end else begin
            qry_n     = CountW'(n_min);
            qry_empty = (n_min == '0);
        end
        // oldest requested slot = write pointer - n, modulo depth
        start_sum = {1'b0, wp_reg} + DepthX - (PW + 1)'(qry_n);
        rd_start  = (start_sum >= DepthX) ? PW'(start_sum - DepthX) : PW'(start_sum);
    end

    always_comb begin
        raw_eff  = invert_reg ? -(33'(raw_reg)) : 33'(raw_reg);
        sum      = 66'(prod_reg) + 66'(offset_reg);
        if (sum > 66'(VAL_MAX)) begin
            val_next = VAL_MAX;
        end else if (sum < 66'(VAL_MIN)) begin
            val_next = VAL_MIN;
        end else begin
            val_next = ValW'(sum);
        end

        diff = (ValW + 1)'(val_reg) - (ValW + 1)'(prev_value_reg);
        if (diff[ValW] != diff[ValW-1]) begin
            delta_sat = diff[ValW] ? VAL_MIN : VAL_MAX;
        end else begin
            delta_sat = ValW'(diff);
        end

        do_delta = delta_en_reg && prev_valid_reg;
        affine   = (gain_reg != GAIN_ONE) || (offset_reg != '0) || invert_reg;

        new_entry.seq_index = seq_reg;
        new_entry.stamp     = stamp_in_reg;
        new_entry.flags     = flags_in_reg | FLAG_VALID
                            | (affine ? FLAG_AFFINE : '0)
                            | (do_delta ? FLAG_DELTA : '0);
        new_entry.value     = val_reg;
        new_entry.delta     = do_delta ? delta_sat : '0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            raw_reg      <= s_data.raw_sample;
            stamp_in_reg <= s_data.time_ticks;
            flags_in_reg <= s_data.in_flags;
        end
        if (cmd.mul) begin
            prod_reg <= 65'(raw_eff) * 65'(gain_reg);
        end
        if (cmd.add) begin
            val_reg <= val_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg         <= '0;
            fill_reg       <= '0;
            seq_reg        <= '0;
            prev_valid_reg <= 1'b0;
            prev_value_reg <= '0;
        end else if (cmd.push_wr) begin
            wp_reg         <= (wp_reg == PtrLast) ? '0 : wp_reg + PW'(1);
            fill_reg       <= (fill_reg == FillFull) ? fill_reg : fill_reg + FW'(1);
            seq_reg        <= seq_reg + 32'd1;
            prev_valid_reg <= 1'b1;
            prev_value_reg <= val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_wr) begin
            mem[wp_reg] <= new_entry;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rd_ptr_reg  <= rd_start;
            rd_left_reg <= qry_n;
        end else if (cmd.rd_load) begin
            rd_ptr_reg  <= (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + PW'(1);
            rd_left_reg <= rd_left_reg - CountW'(1);
        end
    end

    assign status.qry_empty = qry_empty;
    assign status.rd_last   = (rd_left_reg == CountW'(1));
    assign out_take         = out_valid_reg && m_ready;
    assign status.out_free  = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.push_wr || cmd.load_empty || cmd.rd_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_wr) begin
            out_reg.found        <= 1'b1;
            out_reg.seq_index    <= new_entry.seq_index;
            out_reg.stamp        <= new_entry.stamp;
            out_reg.out_flags    <= new_entry.flags;
            out_reg.mapped_value <= new_entry.value;
            out_reg.delta_value  <= new_entry.delta;
            out_reg.last         <= 1'b1;
        end else if (cmd.rd_load) begin
            out_reg.found        <= 1'b1;
            out_reg.seq_index    <= rd_data_reg.seq_index;
            out_reg.stamp        <= rd_data_reg.stamp;
            out_reg.out_flags    <= rd_data_reg.flags;
            out_reg.mapped_value <= rd_data_reg.value;
            out_reg.delta_value  <= rd_data_reg.delta;
            out_reg.last         <= status.rd_last;
        end else if (cmd.load_empty) begin
            out_reg.found        <= 1'b0;
            out_reg.seq_index    <= '0;
            out_reg.stamp        <= '0;
            out_reg.out_flags    <= '0;
            out_reg.mapped_value <= '0;
            out_reg.delta_value  <= '0;
            out_reg.last         <= 1'b1;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

/* src/ssdh_ctrl.sv */
// Controller: sequences push arithmetic, ring reads and output loads.
// Depends on ssdh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssdh_ctrl
    import ssdh_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [1:0]   s_mode,
    input  wire ssdh_status_t status,
    output ssdh_cmd_t         cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b000_0001,
        S_MUL   = 7'b000_0010,
        S_ADD   = 7'b000_0100,
        S_WR    = 7'b000_1000,
        S_EMPTY = 7'b001_0000,
        S_RD    = 7'b010_0000,
        S_LD    = 7'b100_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    case (s_mode)
                        MODE_PUSH:   state_next = S_MUL;
                        MODE_LATEST,
                        MODE_SNAP:   state_next = status.qry_empty ? S_EMPTY : S_RD;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD: begin
                cmd.add    = 1'b1;
                state_next = S_WR;
            end
            S_WR: begin
                if (status.out_free) begin
                    cmd.push_wr = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (status.out_free) begin
                    cmd.load_empty = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_LD;
            end
            S_LD: begin
                if (status.out_free) begin
                    cmd.rd_load = 1'b1;
                    state_next  = status.rd_last ? S_IDLE : S_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* src/sample_scale_delta_history.sv */
// Sample scaler with delta and history ring: top level.
// Instantiates ssdh_ctrl and ssdh_datapath; uses ssdh_pkg and the defines header.
//
// Usage:
//   s_ channel (valid/ready) takes one command word: mode 0 pushes a sample,
//   mode 1 reads the newest packet, mode 2 reads the newest want_count packets
//   (capped at MaxOut and the fill) oldest first, mode 3 is ignored. m_ channel
//   (valid/ready) returns packets; last marks the final word of each reply, and
//   an empty query returns one word with found = 0.
//   cfg_wr_en/cfg_index/cfg_wdata write invert, delta enable, gain, offset;
//   write only while the block is idle.
// Timing:
//   A push shows its packet when s_ready also returns, after its multiply,
//   offset and write stages; no new command is taken until then.
//   A query of n packets shows each one by a registered ring read, then an
//   output load; an empty query answers with a single load of the not-found
//   word.
// Reset clears the history, sequence counter and output valid flag and restores
// the register defaults. A stalled receiver holds the output word; the block
// waits in its load step until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "sample_scale_delta_history_defines.svh"

module sample_scale_delta_history
    import ssdh_pkg::*;
#(
    parameter int RING_DEPTH = RingDepthDefault
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_wr_en,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [ValW-1:0] cfg_wdata,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire ssdh_in_t        s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output ssdh_out_t            m_data
);

    ssdh_cmd_t    cmd;
    ssdh_status_t status;

    ssdh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_data.mode),
        .status  (status),
        .cmd     (cmd)
    );

    ssdh_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // a push keeps the input side busy while its arithmetic runs
    `SSDH_ASSERT_NEXT(a_push_busy, aclk, aresetn, s_valid && s_ready && (s_data.mode == MODE_PUSH), !s_ready)
    // the unused mode produces no work
    `SSDH_ASSERT_NEXT(a_mode_none_idle, aclk, aresetn, s_valid && s_ready && (s_data.mode == MODE_NONE), s_ready)
    // the output register is never overwritten while a word waits
    `SSDH_ASSERT_NOW(a_no_overwrite, aclk, aresetn, m_valid && !m_ready, !(cmd.push_wr || cmd.rd_load || cmd.load_empty))
    // no word is offered right after reset
    `SSDH_ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule

`default_nettype wire
